>>> hw/rtl/piw_pkg.sv
// Package for the point-in-polygon winding block: codes, FSM states and CORDIC constants.
// No dependencies.
package piw_pkg;

    localparam int COORD_W      = 16;
    localparam int DIFF_W       = COORD_W + 1;
    localparam int CORDIC_STEPS = 28;
    localparam int CORDIC_W     = 36;
    localparam int PRESCALE_SH  = 14;
    localparam int OUT_SUM_W    = 24;

    typedef enum logic [1:0] {
        KIND_CLEAR  = 2'd0,
        KIND_APPEND = 2'd1,
        KIND_QUERY  = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } state_t;

    // arctangent of 2^-i, 2^32 units per turn
    localparam logic [31:0] ATAN_TAB [CORDIC_STEPS] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
        32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
        32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
        32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
        32'd81, 32'd41, 32'd20, 32'd10, 32'd5
    };

endpackage

>>> hw/rtl/point_in_polygon_winding.sv
// Top level: polygon edge table in two RAMs plus winding-angle query engine.
// Depends on piw_pkg and piw_cordic.
//
// Channel   | Dir | Handshake                  | Payload
// ----------+-----+----------------------------+----------------------------------------
// s_axis    | in  | s_axis_tvalid/s_axis_tready| tuser: kind; tdata: edge and point fields
// m_axis    | out | m_axis_tvalid/m_axis_tready| tdata: inside_res, angle_sum, edges_dropped
//
// A query reads one stored edge per cycle from the edge RAMs and streams both
// endpoints through two 29-stage CORDIC pipes; the edge RAM read port sets the pace.
// Reset (rst_n, async, low) empties the table and clears the drop flag; the RAMs
// are not cleared. The input is taken only while no query runs; a finished
// result waits in the output register while appends and clears go on.
module point_in_polygon_winding #(
    parameter int EDGE_CAPACITY = 256,
    parameter int ANGLE_BITS    = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // [1:0] kind
    input  logic [1:0]   s_axis_tuser,
    // [15:0] edge_start_x, [31:16] edge_start_y, [47:32] edge_end_x,
    // [63:48] edge_end_y, [64] edge_counted, [80:65] point_x, [96:81] point_y
    input  logic [103:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [0] inside_res, [24:1] angle_sum, [25] edges_dropped
    output logic [31:0]  m_axis_tdata
);
    import piw_pkg::*;

    localparam int CNT_W   = $clog2(EDGE_CAPACITY + 1);
    localparam int IDX_W   = $clog2(EDGE_CAPACITY);
    localparam int SUM_RAW = ANGLE_BITS + 2 + CNT_W;
    localparam int SUM_W   = (SUM_RAW > OUT_SUM_W + 1) ? SUM_RAW : OUT_SUM_W + 1;
    localparam int FL_W    = 6;
    localparam int D_W     = ANGLE_BITS + 2;

    localparam logic [CNT_W-1:0]        CAP     = CNT_W'(EDGE_CAPACITY);
    localparam logic signed [D_W-1:0]   HALF_D  = D_W'(1 << (ANGLE_BITS - 1));
    localparam logic signed [D_W-1:0]   FULL_D  = D_W'(1 << ANGLE_BITS);
    localparam logic signed [SUM_W-1:0] HALF_S  = SUM_W'(1 << (ANGLE_BITS - 1));
    localparam logic signed [SUM_W-1:0] SAT_HI  = SUM_W'(8388607);
    localparam logic signed [SUM_W-1:0] SAT_LO  = SUM_W'(-8388608);

    // edge RAMs: start = {x, y, counted}, end = {x, y}
    logic [2*COORD_W:0]   start_mem [EDGE_CAPACITY];
    logic [2*COORD_W-1:0] end_mem   [EDGE_CAPACITY];

    state_t state_reg, state_next;

    logic [CNT_W-1:0]          cnt_reg;
    logic                      ovf_reg;
    logic [CNT_W-1:0]          idx_reg;
    logic [FL_W-1:0]           flight_reg;
    logic signed [COORD_W-1:0] px_reg, py_reg;
    logic                      rd_v_reg;
    logic [2*COORD_W:0]        start_rd_reg;
    logic [2*COORD_W-1:0]      end_rd_reg;
    logic                      d_v_reg;
    logic                      d_tag_reg;
    logic signed [D_W-1:0]     d_reg;
    logic signed [SUM_W-1:0]   sum_reg;
    logic                      m_valid_reg;
    logic [31:0]               m_data_reg;

    logic   s_fire, issue, finish, walk_done;
    kind_t  kind;

    logic signed [DIFF_W-1:0]     sdx, sdy, edx, edy;
    logic                         c0_valid, c0_tag, c1_valid, c1_tag;
    logic signed [ANGLE_BITS-1:0] t1, t2;
    logic signed [D_W-1:0]        d_raw, d_wrap;
    logic signed [SUM_W-1:0]      sum_sat;
    logic                         inside_hit;

    assign kind      = kind_t'(s_axis_tuser);
    assign s_fire    = s_axis_tvalid && s_axis_tready;
    assign walk_done = (idx_reg == cnt_reg) && (flight_reg == '0);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_fire && (kind == KIND_QUERY))
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (walk_done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!m_valid_reg || m_axis_tready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // FSM outputs
    always_comb
    begin
        s_axis_tready = 1'b0;
        issue         = 1'b0;
        finish        = 1'b0;
        unique case (state_reg)
            ST_IDLE: s_axis_tready = 1'b1;
            ST_RUN:  issue         = (idx_reg != cnt_reg);
            ST_DONE: finish        = !m_valid_reg || m_axis_tready;
            default: s_axis_tready = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            ovf_reg     <= 1'b0;
            idx_reg     <= '0;
            flight_reg  <= '0;
            rd_v_reg    <= 1'b0;
            d_v_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            rd_v_reg  <= issue;
            d_v_reg   <= c0_valid && c1_valid;
            if (s_fire)
            begin
                case (kind)
                    KIND_CLEAR:
                    begin
                        cnt_reg <= '0;
                        ovf_reg <= 1'b0;
                    end
                    KIND_APPEND:
                    begin
                        if (cnt_reg == CAP)
                        begin
                            ovf_reg <= 1'b1;
                        end
                        else
                        begin
                            cnt_reg <= cnt_reg + 1'b1;
                        end
                    end
                    KIND_QUERY:
                    begin
                        idx_reg <= '0;
                    end
                    default:
                    begin
                    end
                endcase
            end
            if (issue)
            begin
                idx_reg <= idx_reg + 1'b1;
            end
            // edges in flight between RAM read and accumulator
            flight_reg <= flight_reg + FL_W'(issue) - FL_W'(d_v_reg);
            if (finish)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // edge RAMs: writes only while idle, reads only during a walk, so no overlap
    always_ff @(posedge clk)
    begin
        if (s_fire && (kind == KIND_APPEND) && (cnt_reg != CAP))
        begin
            start_mem[cnt_reg[IDX_W-1:0]] <= {s_axis_tdata[15:0], s_axis_tdata[31:16],
                                              s_axis_tdata[64]};
            end_mem[cnt_reg[IDX_W-1:0]]   <= {s_axis_tdata[47:32], s_axis_tdata[63:48]};
        end
        if (issue)
        begin
            start_rd_reg <= start_mem[idx_reg[IDX_W-1:0]];
            end_rd_reg   <= end_mem[idx_reg[IDX_W-1:0]];
        end
    end

    // endpoint offsets from the query point
    assign sdx = DIFF_W'($signed(start_rd_reg[2*COORD_W -: COORD_W])) - DIFF_W'(px_reg);
    assign sdy = DIFF_W'($signed(start_rd_reg[COORD_W:1])) - DIFF_W'(py_reg);
    assign edx = DIFF_W'($signed(end_rd_reg[2*COORD_W-1 -: COORD_W])) - DIFF_W'(px_reg);
    assign edy = DIFF_W'($signed(end_rd_reg[COORD_W-1:0])) - DIFF_W'(py_reg);

    piw_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_cordic_start (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (rd_v_reg),
        .in_tag    (start_rd_reg[0]),
        .dx        (sdx),
        .dy        (sdy),
        .out_valid (c0_valid),
        .out_tag   (c0_tag),
        .out_angle (t1)
    );

    piw_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_cordic_end (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (rd_v_reg),
        .in_tag    (start_rd_reg[0]),
        .dx        (edx),
        .dy        (edy),
        .out_valid (c1_valid),
        .out_tag   (c1_tag),
        .out_angle (t2)
    );

    // wrap difference into [-half, half]
    assign d_raw = D_W'(t2) - D_W'(t1);
    always_comb
    begin
        d_wrap = d_raw;
        if (d_raw > HALF_D)
        begin
            d_wrap = d_raw - FULL_D;
        end
        else if (d_raw < -HALF_D)
        begin
            d_wrap = d_raw + FULL_D;
        end
    end

    always_ff @(posedge clk)
    begin
        d_reg     <= d_wrap;
        d_tag_reg <= c0_tag && c1_tag;
        if (s_fire && (kind == KIND_QUERY))
        begin
            px_reg  <= $signed(s_axis_tdata[80:65]);
            py_reg  <= $signed(s_axis_tdata[96:81]);
            sum_reg <= '0;
        end
        else if (d_v_reg && d_tag_reg)
        begin
            sum_reg <= sum_reg + SUM_W'(d_reg);
        end
        if (finish)
        begin
            m_data_reg <= {6'd0, ovf_reg, sum_sat[OUT_SUM_W-1:0], inside_hit};
        end
    end

    assign sum_sat    = (sum_reg > SAT_HI) ? SAT_HI : ((sum_reg < SAT_LO) ? SAT_LO : sum_reg);
    assign inside_hit = (sum_reg >= HALF_S) || (sum_reg <= -HALF_S);

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

endmodule

>>> hw/rtl/piw_cordic.sv
// Pipelined CORDIC vectoring unit: binary angle of (dx, dy), one vector per cycle.
// Depends on piw_pkg.
module piw_cordic #(
    parameter int ANGLE_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  logic                                in_tag,
    input  logic signed [piw_pkg::DIFF_W-1:0]   dx,
    input  logic signed [piw_pkg::DIFF_W-1:0]   dy,
    output logic                                out_valid,
    output logic                                out_tag,
    output logic signed [ANGLE_BITS-1:0]        out_angle
);
    import piw_pkg::*;

    localparam int NS = CORDIC_STEPS;

    logic                       v_reg   [NS+1];
    logic                       tag_reg [NS+1];
    logic                       sp_reg  [NS+1];
    logic [31:0]                sa_reg  [NS+1];
    logic signed [CORDIC_W-1:0] x_reg   [NS+1];
    logic signed [CORDIC_W-1:0] y_reg   [NS+1];
    logic [31:0]                a_reg   [NS+1];

    logic signed [CORDIC_W-1:0] xs0, ys0;
    logic [31:0]                rnd;

    assign xs0 = CORDIC_W'(dx) <<< PRESCALE_SH;
    assign ys0 = CORDIC_W'(dy) <<< PRESCALE_SH;

    // entry stage: axis cases bypass, left half plane is mirrored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg[0] <= 1'b0;
        end
        else
        begin
            v_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        tag_reg[0] <= in_tag;
        sp_reg[0]  <= (dy == '0) || (dx == '0);
        if (dy == '0)
        begin
            sa_reg[0] <= dx[DIFF_W-1] ? 32'h8000_0000 : 32'h0;
        end
        else
        begin
            sa_reg[0] <= (dy > 0) ? 32'h4000_0000 : 32'hC000_0000;
        end
        if (dx[DIFF_W-1])
        begin
            x_reg[0] <= -xs0;
            y_reg[0] <= -ys0;
            a_reg[0] <= 32'h8000_0000;
        end
        else
        begin
            x_reg[0] <= xs0;
            y_reg[0] <= ys0;
            a_reg[0] <= 32'h0;
        end
    end

    for (genvar i = 0; i < NS; i++)
    begin : g_stage
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[i+1] <= 1'b0;
            end
            else
            begin
                v_reg[i+1] <= v_reg[i];
            end
        end

        always_ff @(posedge clk)
        begin
            tag_reg[i+1] <= tag_reg[i];
            sp_reg[i+1]  <= sp_reg[i];
            sa_reg[i+1]  <= sa_reg[i];
            if (y_reg[i] > 0)
            begin
                x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                a_reg[i+1] <= a_reg[i] + ATAN_TAB[i];
            end
            else
            begin
                x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                a_reg[i+1] <= a_reg[i] - ATAN_TAB[i];
            end
        end
    end

    // round half up to ANGLE_BITS
    assign rnd = (sp_reg[NS] ? sa_reg[NS] : a_reg[NS]) + (32'd1 << (31 - ANGLE_BITS));

    assign out_valid = v_reg[NS];
    assign out_tag   = tag_reg[NS];
    assign out_angle = rnd[31 -: ANGLE_BITS];

endmodule

>>> tb/sv/tb.sv
// Testbench for point_in_polygon_winding: edge appends, clears and winding queries.
// Self-checking against an in-bench winding-angle predictor; depends on piw_pkg.
`timescale 1ns / 100ps

module tb;
    import piw_pkg::*;

    localparam int CAP   = 256;
    localparam int ABITS = 16;
    localparam longint HALF = 64'sd1 <<< (ABITS - 1);
    localparam longint FULL = HALF * 2;

    typedef struct packed {
        kind_t             kind;
        logic signed [15:0] sx, sy, ex, ey;
        logic              counted;
        logic signed [15:0] px, py;
    } edge_item_t;

    typedef struct packed {
        logic              in_poly;
        logic signed [23:0] wsum;
        logic              dropped;
    } winding_t;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [1:0]   s_axis_tuser;
    logic [103:0] s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [31:0]  m_axis_tdata;

    point_in_polygon_winding uut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tuser(s_axis_tuser), .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    // predictor copy of the edge table
    logic signed [15:0] tbl_sx [CAP];
    logic signed [15:0] tbl_sy [CAP];
    logic signed [15:0] tbl_ex [CAP];
    logic signed [15:0] tbl_ey [CAP];
    logic               tbl_cnt [CAP];
    int                 tbl_n;
    logic               tbl_ovf;

    edge_item_t pending_items[$];
    winding_t   expected_windings[$];
    int errors;
    int n_queries, n_inside, n_appends;

    localparam logic [31:0] ATANS [CORDIC_STEPS] = ATAN_TAB;

    always
    begin
        clk = 1'b0; #6;
        clk = 1'b1; #6;
    end

    task automatic report(input string what);
    begin
        errors++;
        $display("MISMATCH @%0t: %s", $realtime, what);
    end
    endtask

    task automatic queue_item(input edge_item_t it);
    begin
        pending_items.insert(pending_items.size(), it);
    end
    endtask

    function automatic longint floor_sh(input longint v, input int s);
        return v >>> s;   // arithmetic shift floors
    endfunction

    // binary angle of (dx,dy), signed, in [-half, half)
    function automatic longint bin_angle(input longint dx, input longint dy);
        logic [31:0] ang;
        longint x, y, xs, ys, r;
        ang = 32'd0;
        if (dy == 0)
            ang = (dx < 0) ? 32'h8000_0000 : 32'h0;
        else if (dx == 0)
            ang = (dy > 0) ? 32'h4000_0000 : 32'hC000_0000;
        else
        begin
            x = dx <<< PRESCALE_SH;
            y = dy <<< PRESCALE_SH;
            if (x < 0)
            begin
                x = -x; y = -y; ang = 32'h8000_0000;
            end
            for (int i = 0; i < CORDIC_STEPS; i++)
            begin
                xs = floor_sh(x, i);
                ys = floor_sh(y, i);
                if (y > 0)
                begin
                    x = x + ys; y = y - xs; ang = ang + ATANS[i];
                end
                else
                begin
                    x = x - ys; y = y + xs; ang = ang - ATANS[i];
                end
            end
        end
        r = (longint'({32'd0, ang}) + (64'sd1 <<< (31 - ABITS))) >>> (32 - ABITS);
        r = r & (FULL - 1);
        return (r >= HALF) ? r - FULL : r;
    endfunction

    // apply one input to the table and queue any expected query result
    task automatic predict_item(input edge_item_t it);
        longint total, mag, d, rep;
        winding_t w;
    begin
        case (it.kind)
            KIND_CLEAR:
            begin
                tbl_n = 0; tbl_ovf = 1'b0;
            end
            KIND_APPEND:
            begin
                if (tbl_n >= CAP) tbl_ovf = 1'b1;
                else
                begin
                    tbl_sx[tbl_n] = it.sx; tbl_sy[tbl_n] = it.sy;
                    tbl_ex[tbl_n] = it.ex; tbl_ey[tbl_n] = it.ey;
                    tbl_cnt[tbl_n] = it.counted;
                    tbl_n++;
                end
            end
            KIND_QUERY:
            begin
                total = 0;
                for (int i = 0; i < tbl_n; i++)
                begin
                    if (!tbl_cnt[i]) continue;
                    d = bin_angle(longint'(tbl_ex[i]) - it.px, longint'(tbl_ey[i]) - it.py)
                      - bin_angle(longint'(tbl_sx[i]) - it.px, longint'(tbl_sy[i]) - it.py);
                    if (d > HALF) d -= FULL;
                    if (d < -HALF) d += FULL;
                    total += d;
                end
                mag = (total < 0) ? -total : total;
                rep = total;
                if (rep > 8388607) rep = 8388607;
                if (rep < -8388608) rep = -8388608;
                w.in_poly = (mag >= HALF);
                w.wsum = rep[23:0];
                w.dropped = tbl_ovf;
                expected_windings.insert(expected_windings.size(), w);
                n_queries++;
                if (w.in_poly) n_inside++;
            end
            default: ;
        endcase
    end
    endtask

    function automatic edge_item_t mk(input kind_t k, input int sx, sy, ex, ey,
                                      input bit c, input int px, py);
        edge_item_t it;
        it.kind = k; it.sx = 16'(sx); it.sy = 16'(sy); it.ex = 16'(ex); it.ey = 16'(ey);
        it.counted = c; it.px = 16'(px); it.py = 16'(py);
        return it;
    endfunction

    function automatic int rcoord(input int span);
        return $urandom_range(2 * span) - span;
    endfunction

    function automatic edge_item_t rnd_any(input kind_t k);
        edge_item_t it;
        it = edge_item_t'({$urandom, $urandom, $urandom, $urandom});
        it.kind = k;
        return it;
    endfunction

    // closed random polygon, then a few queries around it
    task automatic add_polygon(input int nverts, input int span);
        int vx[$], vy[$];
        int cx, cy;
        bit c;
    begin
        cx = rcoord(30000 - span); cy = rcoord(30000 - span);
        for (int i = 0; i < nverts; i++)
        begin
            vx.insert(vx.size(), cx + rcoord(span));
            vy.insert(vy.size(), cy + rcoord(span));
        end
        for (int i = 0; i < nverts; i++)
        begin
            c = ($urandom_range(9) != 0);
            queue_item(mk(KIND_APPEND, vx[i], vy[i], vx[(i + 1) % nverts],
                          vy[(i + 1) % nverts], c, 0, 0));
        end
        for (int q = 0; q < 3; q++)
        begin
            if ($urandom_range(2) == 0)
                queue_item(mk(KIND_QUERY, 0, 0, 0, 0, 0, vx[0], vy[0]));
            else
                queue_item(mk(KIND_QUERY, 0, 0, 0, 0, 0,
                              cx + rcoord(span), cy + rcoord(span)));
        end
    end
    endtask

    // driver: one transfer per item with a random gap before each
    int gap_cnt;
    bit have_item;
    edge_item_t cur;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tuser  <= '0;
            s_axis_tdata  <= '0;
            have_item = 0;
            gap_cnt = 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                predict_item(cur);
                have_item = 0;
            end
            if (!have_item && pending_items.size() > 0)
            begin
                cur = pending_items.pop_front();
                have_item = 1;
                gap_cnt = $urandom_range(3) == 0 ? 0 : $urandom_range(13);
            end
            if (have_item && gap_cnt > 0)
            begin
                gap_cnt--;
                s_axis_tvalid <= 1'b0;
            end
            else if (have_item)
            begin
                s_axis_tvalid <= 1'b1;
                s_axis_tuser  <= cur.kind;
                s_axis_tdata  <= {7'd0, cur.py, cur.px, cur.counted,
                                  cur.ey, cur.ex, cur.sy, cur.sx};
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // monitor: random stalls on the result side and field checks
    int stall_cnt;
    winding_t got, want;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            stall_cnt = 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = {m_axis_tdata[0], m_axis_tdata[24:1], m_axis_tdata[25]};
                if (expected_windings.size() == 0)
                    report("result with nothing expected");
                else
                begin
                    want = expected_windings.pop_front();
                    if (got.in_poly !== want.in_poly)
                        report($sformatf("inside %0b exp %0b", got.in_poly, want.in_poly));
                    if (got.wsum !== want.wsum)
                        report($sformatf("angle_sum %0d exp %0d", got.wsum, want.wsum));
                    if (got.dropped !== want.dropped)
                        report($sformatf("dropped %0b exp %0b", got.dropped, want.dropped));
                end
                stall_cnt = $urandom_range(3) == 0 ? 0 : $urandom_range(13);
            end
            if (stall_cnt > 0)
            begin
                stall_cnt--;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    initial
    begin
        #(12ns * 2_000_000);
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        errors = 0; n_queries = 0; n_inside = 0; n_appends = 0;
        tbl_n = 0; tbl_ovf = 1'b0;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0; s_axis_tuser = '0; s_axis_tdata = '0;
        m_axis_tready = 1'b0;

        // directed: empty table, axis cases, extremes, ignored kind, uncounted edge
        queue_item(mk(KIND_QUERY, 0, 0, 0, 0, 0, -32768, 32767));
        queue_item(mk(KIND_APPEND, 10, 0, 0, 10, 1, 0, 0));
        queue_item(mk(KIND_APPEND, 0, 10, -10, 0, 1, 0, 0));
        queue_item(mk(KIND_APPEND, -10, 0, 0, -10, 1, 0, 0));
        queue_item(mk(KIND_APPEND, 0, -10, 10, 0, 1, 0, 0));
        queue_item(mk(KIND_QUERY, 0, 0, 0, 0, 0, 0, 0));
        queue_item(mk(KIND_QUERY, 0, 0, 0, 0, 0, 10, 0));
        queue_item(mk(KIND_QUERY, 0, 0, 0, 0, 0, 100, 3));
        queue_item(rnd_any(kind_t'(2'd3)));
        queue_item(mk(KIND_CLEAR, 0, 0, 0, 0, 0, 0, 0));
        queue_item(mk(KIND_APPEND, -32768, -32768, 32767, 32767, 1, 0, 0));
        queue_item(mk(KIND_APPEND, 32767, -32768, -32768, 32767, 1, 0, 0));
        queue_item(mk(KIND_APPEND, 5, 5, -5, -5, 0, 0, 0));
        queue_item(mk(KIND_QUERY, 0, 0, 0, 0, 0, 32767, -32768));
        queue_item(mk(KIND_QUERY, 0, 0, 0, 0, 0, 0, 0));
        queue_item(mk(KIND_QUERY, 0, 0, 0, 0, 0, -32768, -32768));
        // fill past capacity to set the drop flag, then clear it
        queue_item(mk(KIND_CLEAR, 0, 0, 0, 0, 0, 0, 0));
        for (int i = 0; i < CAP + 2; i++)
            queue_item(rnd_any(KIND_APPEND));
        queue_item(rnd_any(KIND_QUERY));
        queue_item(mk(KIND_CLEAR, 0, 0, 0, 0, 0, 0, 0));
        queue_item(rnd_any(KIND_QUERY));

        // random: mostly closed polygons with queries, some noise
        while (pending_items.size() < 500)
        begin
            case ($urandom_range(9))
                0: queue_item(rnd_any(KIND_APPEND));
                1: queue_item(rnd_any(KIND_QUERY));
                2: queue_item(rnd_any(kind_t'($urandom_range(3))));
                default:
                begin
                    if ($urandom_range(1)) queue_item(rnd_any(KIND_CLEAR));
                    add_polygon($urandom_range(3, 12),
                                $urandom_range(1) ? $urandom_range(4, 200) : 20000);
                end
            endcase
        end
        foreach (pending_items[i])
            if (pending_items[i].kind == KIND_APPEND) n_appends++;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_items.size() != 0 || have_item || expected_windings.size() != 0)
            @(posedge clk);
        repeat (400) @(posedge clk);

        $display("Covered %0d appends and %0d queries (%0d inside), incl. table overflow.",
                 n_appends, n_queries, n_inside);
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule

>>> sim.f
hw/rtl/piw_pkg.sv
hw/rtl/piw_cordic.sv
hw/rtl/point_in_polygon_winding.sv
tb/sv/tb.sv
